@@ rtl/ntsel_pkg.sv @@
`default_nettype none

package ntsel_pkg;

  // Widths fixed by the register map and the item fields.
  localparam int CNT_W = 13;
  localparam int IDX_W = 12;
  localparam int STEP_W = 4;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_INDEX_W = 2;

  localparam int SEEK_SLACK_MS = 50;
  localparam logic [STEP_W-1:0] STEP_RESET = 4'd10;
  localparam logic [STEP_W-1:0] STEP_COUNT_MAX = 4'd15;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_FRAME = 2'd2
  } ntsel_op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_STEP_LENGTH = 2'd0,
    CFG_RANGE_FIRST = 2'd1,
    CFG_RANGE_LAST  = 2'd2,
    CFG_ENTRY_COUNT = 2'd3
  } ntsel_cfg_t;

  typedef enum logic [2:0] {
    STAT_HANDLED  = 3'd0,
    STAT_BEGUN    = 3'd1,
    STAT_REJECTED = 3'd2,
    STAT_ENDED    = 3'd3,
    STAT_IGNORED  = 3'd4
  } ntsel_status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BEGIN_RD,
    ST_BEGIN_SET,
    ST_SEARCH_START,
    ST_SEARCH,
    ST_NEAR_HI,
    ST_NEAR_LO,
    ST_PICK,
    ST_DECIDE,
    ST_EMIT
  } ntsel_state_t;

endpackage

`default_nettype wire

@@ rtl/nearest_timestamp_sparse_cache_select_unit.sv @@
// Nearest-timestamp sparse cache selector.
// Three channels, each with valid/ready: the item request channel (in_*), the result
// channel (out_*) and a register write channel (cfg_*). The register channel is always
// ready; registers are meant to be written while no item is in flight.
// A load request writes one table entry and clears its cached flag and gives no result.
// A begin request sets up the run from the first range entry's time; a rejected begin
// goes straight to its result. A decoded-frame request runs a lower-bound search over
// the time table, one memory probe per cycle through the single read port of the table
// RAM, ceil(log2(entry_count + 1)) probes, at most 13. Frames outside a run go straight
// to their result; frames without a timestamp skip the search. The block handles one
// request at a time; in_ready is high only while it waits for a new request.
// The result sits in an output register, so a new request is taken while a result still
// waits; if the receiver stalls long enough the next result waits in its last stage
// until the output register frees up, and in_ready stays low meanwhile.
// After reset a clearing pass walks the cached-flag RAM, one entry per cycle, over all
// TABLE_DEPTH entries (4096 by default) with in_ready low. The time table is not cleared;
// its entries must be loaded before they are used.
`default_nettype none

module nearest_timestamp_sparse_cache_select_unit
  import ntsel_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096,
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,

  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_opcode,
  input  wire logic [IDX_W-1:0]       in_entry_index,
  input  wire logic signed [31:0]     in_entry_time_ms,
  input  wire logic signed [31:0]     in_frame_time_ms,
  input  wire logic                   in_has_timestamp,
  input  wire logic                   in_key_frame,
  input  wire logic                   in_decode_error,
  input  wire logic                   in_picture_sound,

  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [2:0]                  out_status,
  output logic                        out_index_found,
  output logic [IDX_W-1:0]            out_frame_index,
  output logic                        out_store_frame
);

  localparam int TW = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;
  localparam int DW = TW + 1;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  function automatic logic [DW-1:0] abs_diff(input logic signed [TW-1:0] a,
                                             input logic signed [TW-1:0] b);
    logic signed [DW-1:0] ab;
    logic signed [DW-1:0] ba;
    ab = $signed({a[TW-1], a}) - $signed({b[TW-1], b});
    ba = $signed({b[TW-1], b}) - $signed({a[TW-1], a});
    return ab[DW-1] ? ba : ab;
  endfunction

  // Registers.
  ntsel_state_t         state_r, state_nxt;
  logic [AW-1:0]        clr_r;
  logic [STEP_W-1:0]    step_r;
  logic [IDX_W-1:0]     first_r;
  logic [IDX_W-1:0]     last_r;
  logic [CNT_W-1:0]     count_r;

  logic                 run_active_r, run_active_nxt;
  logic [IDX_W-1:0]     run_last_r, run_last_nxt;
  logic signed [DW-1:0] seek_lo_r, seek_lo_nxt;
  logic                 first_stored_r, first_stored_nxt;
  logic [CNT_W-1:0]     fsi_r, fsi_nxt;
  logic [STEP_W-1:0]    fss_r, fss_nxt;

  logic signed [TW-1:0] t_r, t_nxt;
  logic                 key_r, key_nxt;
  logic                 ps_r, ps_nxt;
  logic [CNT_W-1:0]     lo_r, lo_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 v0_r, v0_nxt;
  logic [DW-1:0]        d0_r, d0_nxt;
  logic                 v1_r, v1_nxt;
  logic [DW-1:0]        d1_r, d1_nxt;
  logic                 found_r, found_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;

  ntsel_status_t        res_status_r, res_status_nxt;
  logic                 res_found_r, res_found_nxt;
  logic [IDX_W-1:0]     res_index_r, res_index_nxt;
  logic                 res_store_r, res_store_nxt;

  logic                 out_valid_r, out_valid_nxt;
  ntsel_status_t        out_status_r;
  logic                 out_found_r;
  logic [IDX_W-1:0]     out_index_r;
  logic                 out_store_r;

  // RAM ports.
  logic                 tt_we;
  logic [AW-1:0]        tt_waddr;
  logic [TW-1:0]        tt_wdata;
  logic [CNT_W-1:0]     tt_raddr;
  logic [TW-1:0]        tt_rdata;
  logic                 fl_we;
  logic [AW-1:0]        fl_waddr;
  logic [0:0]           fl_wdata;
  logic [CNT_W-1:0]     fl_raddr;
  logic [0:0]           fl_rdata;

  // Shared decode of the accepted request.
  logic                 in_fire;
  ntsel_op_t            in_op;
  logic                 load_ok;
  logic [CNT_W-1:0]     count_m1;
  logic                 begin_reject;
  logic                 frame_short;
  logic                 emit_fire;
  logic                 clr_done;

  assign in_fire   = in_valid && in_ready;
  assign in_op     = ntsel_op_t'(in_opcode);
  assign load_ok   = 32'(in_entry_index) < TABLE_DEPTH;
  assign count_m1  = count_r - CNT_W'(1);
  assign begin_reject = (count_r == '0) || (first_r > last_r) ||
                        ({1'b0, first_r} >= count_r);
  assign frame_short = !in_has_timestamp || (count_r == '0);
  assign emit_fire = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign clr_done  = (clr_r == LAST_ADDR);

  // Search step: the probe result of this cycle picks one of two precomputed next probes.
  logic                 s_less;
  logic [CNT_W-1:0]     s_half;
  logic [CNT_W-1:0]     s_lo_a, s_cnt_a, s_addr_a, s_addr_b;
  logic [CNT_W-1:0]     s_lo_n, s_cnt_n, s_probe;

  assign s_less   = $signed(tt_rdata) < t_r;
  assign s_half   = cnt_r >> 1;
  assign s_lo_a   = lo_r + s_half + CNT_W'(1);
  assign s_cnt_a  = cnt_r - s_half - CNT_W'(1);
  assign s_addr_a = s_lo_a + (s_cnt_a >> 1);
  assign s_addr_b = lo_r + (s_half >> 1);
  assign s_lo_n   = s_less ? s_lo_a : lo_r;
  assign s_cnt_n  = s_less ? s_cnt_a : s_half;
  assign s_probe  = (s_cnt_n == '0) ? s_lo_n : (s_less ? s_addr_a : s_addr_b);

  // Decision inputs.
  logic                 pick_lo1;
  logic                 in_range;
  logic                 past_end;
  logic                 first_ok;
  logic [STEP_W-1:0]    fss_inc;
  logic                 want;
  logic                 do_store;

  assign pick_lo1 = v1_r && (!v0_r || (d1_r < d0_r));
  assign in_range = found_r && (idx_r >= {1'b0, first_r}) && (idx_r <= {1'b0, run_last_r});
  assign past_end = found_r && (idx_r > {1'b0, run_last_r});
  assign first_ok = key_r && ($signed({t_r[TW-1], t_r}) >= seek_lo_r);
  assign fss_inc  = (fss_r != STEP_COUNT_MAX) ? fss_r + STEP_W'(1) : fss_r;
  assign want     = in_range && (first_stored_r ? (fss_inc >= step_r) : first_ok);
  assign do_store = want && (first_stored_r ? (idx_r >= fsi_r) : 1'b1) &&
                    !fl_rdata[0] && ps_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_LOAD:  state_nxt = ST_IDLE;
            OP_BEGIN: state_nxt = begin_reject ? ST_EMIT : ST_BEGIN_RD;
            OP_FRAME: begin
              if (!run_active_r) state_nxt = ST_EMIT;
              else if (in_decode_error) state_nxt = ST_IDLE;
              else if (frame_short) state_nxt = ST_DECIDE;
              else state_nxt = ST_SEARCH_START;
            end
            default:  state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_BEGIN_RD:     state_nxt = ST_BEGIN_SET;
      ST_BEGIN_SET:    state_nxt = ST_EMIT;
      ST_SEARCH_START: state_nxt = ST_SEARCH;
      ST_SEARCH: begin
        if (s_cnt_n == '0) state_nxt = ST_NEAR_HI;
      end
      ST_NEAR_HI:      state_nxt = ST_NEAR_LO;
      ST_NEAR_LO:      state_nxt = ST_PICK;
      ST_PICK:         state_nxt = ST_DECIDE;
      ST_DECIDE:       state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_fire) state_nxt = ST_IDLE;
      end
      default:         state_nxt = ST_IDLE;
    endcase
  end

  // Memory control.
  always_comb begin
    tt_we    = 1'b0;
    tt_waddr = AW'(in_entry_index);
    tt_wdata = in_entry_time_ms[TW-1:0];
    tt_raddr = lo_r;
    fl_we    = 1'b0;
    fl_waddr = AW'(idx_r);
    fl_wdata = 1'b0;
    fl_raddr = idx_r;
    case (state_r)
      ST_CLEAR: begin
        fl_we    = 1'b1;
        fl_waddr = clr_r;
      end
      ST_IDLE: begin
        if (in_fire && (in_op == OP_LOAD) && load_ok) begin
          tt_we    = 1'b1;
          fl_we    = 1'b1;
          fl_waddr = AW'(in_entry_index);
        end
      end
      ST_BEGIN_RD:     tt_raddr = {1'b0, first_r};
      ST_SEARCH_START: tt_raddr = cnt_r >> 1;
      ST_SEARCH:       tt_raddr = s_probe;
      ST_NEAR_HI:      tt_raddr = lo_r - CNT_W'(1);
      ST_PICK:         fl_raddr = pick_lo1 ? lo_r - CNT_W'(1) : lo_r;
      ST_DECIDE: begin
        fl_we    = do_store;
        fl_wdata = 1'b1;
      end
      default: begin
        tt_raddr = lo_r;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    run_active_nxt   = run_active_r;
    run_last_nxt     = run_last_r;
    seek_lo_nxt      = seek_lo_r;
    first_stored_nxt = first_stored_r;
    fsi_nxt          = fsi_r;
    fss_nxt          = fss_r;
    t_nxt            = t_r;
    key_nxt          = key_r;
    ps_nxt           = ps_r;
    lo_nxt           = lo_r;
    cnt_nxt          = cnt_r;
    v0_nxt           = v0_r;
    d0_nxt           = d0_r;
    v1_nxt           = v1_r;
    d1_nxt           = d1_r;
    found_nxt        = found_r;
    idx_nxt          = idx_r;
    res_status_nxt   = res_status_r;
    res_found_nxt    = res_found_r;
    res_index_nxt    = res_index_r;
    res_store_nxt    = res_store_r;
    case (state_r)
      ST_IDLE: begin
        res_found_nxt = 1'b0;
        res_index_nxt = '0;
        res_store_nxt = 1'b0;
        res_status_nxt = STAT_IGNORED;
        t_nxt   = in_frame_time_ms[TW-1:0];
        key_nxt = in_key_frame;
        ps_nxt  = in_picture_sound;
        lo_nxt  = '0;
        cnt_nxt = count_r;
        found_nxt = 1'b0;
        if (in_fire && (in_op == OP_BEGIN) && begin_reject) begin
          run_active_nxt = 1'b0;
          res_status_nxt = STAT_REJECTED;
        end
      end
      ST_BEGIN_SET: begin
        run_last_nxt = ({1'b0, last_r} < count_m1) ? last_r : count_m1[IDX_W-1:0];
        // A negative first entry time means the seek target is zero.
        seek_lo_nxt = (tt_rdata[TW-1] ? DW'(0) : {1'b0, tt_rdata}) - DW'(SEEK_SLACK_MS);
        first_stored_nxt = 1'b0;
        fss_nxt          = '0;
        run_active_nxt   = 1'b1;
        res_status_nxt   = STAT_BEGUN;
      end
      ST_SEARCH: begin
        lo_nxt  = s_lo_n;
        cnt_nxt = s_cnt_n;
      end
      ST_NEAR_HI: begin
        v0_nxt = (lo_r < count_r) && !tt_rdata[TW-1];
        d0_nxt = abs_diff($signed(tt_rdata), t_r);
      end
      ST_NEAR_LO: begin
        v1_nxt = (lo_r != '0) && !tt_rdata[TW-1];
        d1_nxt = abs_diff($signed(tt_rdata), t_r);
      end
      ST_PICK: begin
        found_nxt = v0_r || v1_r;
        idx_nxt   = pick_lo1 ? lo_r - CNT_W'(1) : lo_r;
      end
      ST_DECIDE: begin
        if (in_range) begin
          if (!first_stored_r) begin
            if (first_ok) begin
              first_stored_nxt = 1'b1;
              fsi_nxt          = idx_r;
              fss_nxt          = '0;
            end
          end else begin
            fss_nxt = (fss_inc >= step_r) ? '0 : fss_inc;
          end
        end
        if (past_end) begin
          run_active_nxt = 1'b0;
        end
        res_status_nxt = past_end ? STAT_ENDED : STAT_HANDLED;
        res_found_nxt  = found_r;
        res_index_nxt  = found_r ? idx_r[IDX_W-1:0] : '0;
        res_store_nxt  = do_store;
      end
      default: begin
        res_status_nxt = res_status_r;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || emit_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_r          <= '0;
      step_r         <= STEP_RESET;
      first_r        <= '0;
      last_r         <= '0;
      count_r        <= '0;
      run_active_r   <= 1'b0;
      run_last_r     <= '0;
      seek_lo_r      <= -DW'(SEEK_SLACK_MS);
      first_stored_r <= 1'b0;
      fss_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        case (ntsel_cfg_t'(cfg_index))
          CFG_STEP_LENGTH: step_r  <= cfg_data[STEP_W-1:0];
          CFG_RANGE_FIRST: first_r <= cfg_data[IDX_W-1:0];
          CFG_RANGE_LAST:  last_r  <= cfg_data[IDX_W-1:0];
          CFG_ENTRY_COUNT: begin
            if (32'(cfg_data) > TABLE_DEPTH) count_r <= CNT_W'(TABLE_DEPTH);
            else count_r <= cfg_data;
          end
          default: step_r <= step_r;
        endcase
      end
      run_active_r   <= run_active_nxt;
      run_last_r     <= run_last_nxt;
      seek_lo_r      <= seek_lo_nxt;
      first_stored_r <= first_stored_nxt;
      fss_r          <= fss_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fsi_r        <= fsi_nxt;
    t_r          <= t_nxt;
    key_r        <= key_nxt;
    ps_r         <= ps_nxt;
    lo_r         <= lo_nxt;
    cnt_r        <= cnt_nxt;
    v0_r         <= v0_nxt;
    d0_r         <= d0_nxt;
    v1_r         <= v1_nxt;
    d1_r         <= d1_nxt;
    found_r      <= found_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_index_r  <= res_index_nxt;
    res_store_r  <= res_store_nxt;
    if (emit_fire) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_index_r  <= res_index_r;
      out_store_r  <= res_store_r;
    end
  end

  ntsel_ram #(
    .WIDTH(TW),
    .DEPTH(TABLE_DEPTH)
  ) u_time_ram (
    .clk   (clk),
    .we    (tt_we),
    .waddr (tt_waddr),
    .wdata (tt_wdata),
    .raddr (AW'(tt_raddr)),
    .rdata (tt_rdata)
  );

  ntsel_ram #(
    .WIDTH(1),
    .DEPTH(TABLE_DEPTH)
  ) u_flag_ram (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .raddr (AW'(fl_raddr)),
    .rdata (fl_rdata)
  );

  assign cfg_ready       = 1'b1;
  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_index_found = out_found_r;
  assign out_frame_index = out_index_r;
  assign out_store_frame = out_store_r;

`ifndef SYNTHESIS
  a_no_request_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("request accepted during flag clearing pass");

  a_search_never_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (cnt_r != '0))
    else $error("search step with an empty interval");

  a_store_needs_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_store_frame) |-> (out_index_found && (out_status == STAT_HANDLED)))
    else $error("store flagged without a handled, found index");

  a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_valid_r && !out_ready) |=> (state_r == ST_EMIT))
    else $error("result left its last stage while the output was stalled");

  a_first_store_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(first_stored_r) |-> ($past(state_r) == ST_DECIDE))
    else $error("first store marked outside the decision step");
`endif

endmodule

`default_nettype wire

@@ rtl/ntsel_ram.sv @@
`default_nettype none

module ntsel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sim/nearest_timestamp_sparse_cache_select_unit_tb.sv @@
`timescale 1ns / 1ps

module nearest_timestamp_sparse_cache_select_unit_tb;
  import ntsel_pkg::*;

  localparam int DEPTH = 4096;
  localparam logic [1:0] OP_UNDEFINED = 2'd3;

  typedef struct {
    logic [1:0]        op;
    logic [IDX_W-1:0]  index;
    logic signed [31:0] entry_ms;
    logic signed [31:0] frame_ms;
    logic              has_ts;
    logic              key;
    logic              dec_err;
    logic              sound;
  } request_t;

  typedef struct {
    ntsel_status_t     status;
    logic              found;
    logic [IDX_W-1:0]  index;
    logic              store;
  } frame_result_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_opcode;
  logic [IDX_W-1:0] in_entry_index;
  logic signed [31:0] in_entry_time_ms;
  logic signed [31:0] in_frame_time_ms;
  logic in_has_timestamp;
  logic in_key_frame;
  logic in_decode_error;
  logic in_picture_sound;
  logic out_valid;
  logic out_ready;
  logic [2:0] out_status;
  logic out_index_found;
  logic [IDX_W-1:0] out_frame_index;
  logic out_store_frame;

  // Shadow copy of the selector: time table, cached flags, run state and registers.
  int table_ms [DEPTH];
  bit slot_cached [DEPTH];
  longint seek_ms = 0;
  bit have_first = 1'b0;
  int first_idx = 'h1FFF;
  int step_count = 0;
  bit run_on = 1'b0;
  int run_end = 0;
  int cfg_step = STEP_RESET;
  int cfg_first = 0;
  int cfg_last = 0;
  int cfg_count = 0;

  frame_result_t pending_outcomes [$];
  frame_result_t oldest_outcome;
  int mismatch_count = 0;
  int results_seen = 0;
  int items_sent = 0;
  int hold_off_cycles = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;

  nearest_timestamp_sparse_cache_select_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_entry_index   (in_entry_index),
    .in_entry_time_ms (in_entry_time_ms),
    .in_frame_time_ms (in_frame_time_ms),
    .in_has_timestamp (in_has_timestamp),
    .in_key_frame     (in_key_frame),
    .in_decode_error  (in_decode_error),
    .in_picture_sound (in_picture_sound),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_index_found  (out_index_found),
    .out_frame_index  (out_frame_index),
    .out_store_frame  (out_store_frame)
  );

  // Updates the shadow state for one accepted request; returns 1 when a result is due.
  function automatic bit select_outcome(input request_t r, output frame_result_t res);
    int lo, cnt, half, idx;
    bit found, want;
    longint t, best, d, e;
    res = '{STAT_IGNORED, 1'b0, '0, 1'b0};
    found = 1'b0;
    want = 1'b0;
    idx = 0;
    if (r.op == OP_LOAD) begin
      table_ms[r.index] = r.entry_ms;
      slot_cached[r.index] = 1'b0;
      return 1'b0;
    end
    if (r.op == OP_BEGIN) begin
      if (cfg_count == 0 || cfg_first > cfg_last || cfg_first >= cfg_count) begin
        run_on = 1'b0;
        res.status = STAT_REJECTED;
      end else begin
        run_end = (cfg_last < cfg_count - 1) ? cfg_last : cfg_count - 1;
        seek_ms = table_ms[cfg_first];
        if (seek_ms < 0) seek_ms = 0;
        have_first = 1'b0;
        first_idx = 'h1FFF;
        step_count = 0;
        run_on = 1'b1;
        res.status = STAT_BEGUN;
      end
      return 1'b1;
    end
    if (r.op != OP_FRAME || !run_on) return 1'b1;
    if (r.dec_err) return 1'b0;
    t = r.frame_ms;
    if (r.has_ts) begin
      // Lower bound; a plain signed compare already puts unset (negative) times first.
      lo = 0;
      cnt = cfg_count;
      while (cnt > 0) begin
        half = cnt / 2;
        if (table_ms[lo + half] < t) begin
          lo += half + 1;
          cnt -= half + 1;
        end else begin
          cnt = half;
        end
      end
      best = 64'sh7FFF_FFFF_FFFF_FFFF;
      if (lo < cfg_count && table_ms[lo] >= 0) begin
        e = table_ms[lo];
        best = (e >= t) ? e - t : t - e;
        idx = lo;
        found = 1'b1;
      end
      if (lo > 0 && table_ms[lo - 1] >= 0) begin
        e = table_ms[lo - 1];
        d = (e >= t) ? e - t : t - e;
        if (d < best || (d == best && !found)) begin
          idx = lo - 1;
          found = 1'b1;
        end
      end
    end
    res.status = STAT_HANDLED;
    if (found && idx >= cfg_first && idx <= run_end) begin
      if (!have_first) begin
        if (r.key && t >= seek_ms - SEEK_SLACK_MS) begin
          want = 1'b1;
          have_first = 1'b1;
          first_idx = idx;
          step_count = 0;
        end
      end else begin
        if (step_count < STEP_COUNT_MAX) step_count++;
        if (step_count >= cfg_step) begin
          want = 1'b1;
          step_count = 0;
        end
      end
      if (want && idx >= first_idx && !slot_cached[idx] && r.sound) begin
        slot_cached[idx] = 1'b1;
        res.store = 1'b1;
      end
    end
    if (found && idx > run_end) begin
      res.status = STAT_ENDED;
      run_on = 1'b0;
    end
    res.found = found;
    res.index = found ? IDX_W'(idx) : '0;
    return 1'b1;
  endfunction

  function automatic request_t random_request(input logic [1:0] op);
    request_t r;
    r.op = op;
    r.index = $urandom;
    r.entry_ms = $urandom;
    r.frame_ms = $urandom;
    r.has_ts = $urandom;
    r.key = $urandom;
    r.dec_err = $urandom;
    r.sound = $urandom;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 50)
      $display("%0t: %s mismatch on result %0d: got %0d, want %0d",
               $time, what, results_seen, got, want);
    mismatch_count++;
  endtask

  task automatic send_request(input request_t r);
    frame_result_t res;
    int gap, p;
    @(negedge clk);
    in_valid <= 1'b1;
    in_opcode <= r.op;
    in_entry_index <= r.index;
    in_entry_time_ms <= r.entry_ms;
    in_frame_time_ms <= r.frame_ms;
    in_has_timestamp <= r.has_ts;
    in_key_frame <= r.key;
    in_decode_error <= r.dec_err;
    in_picture_sound <= r.sound;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (select_outcome(r, res)) pending_outcomes.push_back(res);
    items_sent++;
    gap = 0;
    if (tx_gaps_on) begin
      p = $urandom_range(0, 99);
      if (p >= 95) gap = $urandom_range(10, 30);
      else if (p >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_simple(input logic [1:0] op);
    send_request(random_request(op));
  endtask

  task automatic send_frame(input logic signed [31:0] t, input bit ts, input bit key,
                            input bit err, input bit sound);
    request_t r;
    r = random_request(OP_FRAME);
    r.frame_ms = t;
    r.has_ts = ts;
    r.key = key;
    r.dec_err = err;
    r.sound = sound;
    send_request(r);
  endtask

  task automatic load_entry(input int idx, input logic signed [31:0] t);
    request_t r;
    r = random_request(OP_LOAD);
    r.index = idx;
    r.entry_ms = t;
    send_request(r);
  endtask

  task automatic park_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Load requests and frames with decode errors give no result, so allow time for the
  // slowest search to finish after the last result before touching the registers.
  task automatic wait_idle();
    park_input();
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input ntsel_cfg_t idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_STEP_LENGTH: cfg_step = value & 'hF;
      CFG_RANGE_FIRST: cfg_first = value & 'hFFF;
      CFG_RANGE_LAST:  cfg_last = value & 'hFFF;
      CFG_ENTRY_COUNT: cfg_count = ((value & 'h1FFF) > DEPTH) ? DEPTH : (value & 'h1FFF);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Writes entries 0..n-1: mostly sorted with a few unset times first, sometimes random.
  task automatic fill_time_table(input int n, input bit sorted);
    int i, negs;
    longint t;
    negs = sorted ? $urandom_range(0, (n > 3) ? 3 : n - 1) : 0;
    t = ($urandom_range(0, 3) == 0) ? -64'sd2147483648 : -longint'($urandom_range(10, 5000));
    for (i = 0; i < n; i++) begin
      if (!sorted) begin
        load_entry(i, $urandom);
      end else begin
        if (i == negs)
          t = $urandom_range(0, 1) ? longint'($urandom_range(0, 500))
                                   : longint'($urandom_range(0, 32'h7FF0_0000));
        load_entry(i, 32'(t));
        t += (i < negs) ? $urandom_range(1, 3) : $urandom_range(0, 40);
      end
    end
  endtask

  // A decoding pass: frame times follow the table upward from the range start, with some
  // noise requests, fully random times and fresh begins once a run has ended.
  task automatic drive_run_frames(input int count);
    request_t r;
    int cur, sel;
    longint t;
    cur = cfg_first - $urandom_range(0, 2);
    if (cur < 0) cur = 0;
    if (cur >= cfg_count) cur = (cfg_count > 0) ? cfg_count - 1 : 0;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (!run_on && $urandom_range(0, 3) != 0) begin
        r = random_request(OP_BEGIN);
        cur = (cfg_first < cfg_count) ? cfg_first : 0;
      end else if (sel < 3) begin
        r = random_request(OP_LOAD);
        r.index = (cfg_count > 0) ? $urandom_range(0, cfg_count - 1) : 0;
      end else if (sel < 5) begin
        r = random_request(OP_BEGIN);
      end else if (sel < 7) begin
        r = random_request(OP_UNDEFINED);
      end else begin
        r = random_request(OP_FRAME);
        if (cfg_count > 0 && $urandom_range(0, 19) != 0) begin
          t = longint'(table_ms[cur]) + longint'($urandom_range(0, 120)) - 60;
          if (t > 64'sd2147483647) t = 64'sd2147483647;
          if (t < -64'sd2147483648) t = -64'sd2147483648;
          r.frame_ms = 32'(t);
        end
        r.has_ts = $urandom_range(0, 99) < 92;
        r.key = $urandom_range(0, 99) < 25;
        r.dec_err = $urandom_range(0, 99) < 5;
        r.sound = $urandom_range(0, 99) < 90;
        if ($urandom_range(0, 2) == 0 && cur < cfg_count - 1) cur++;
      end
      send_request(r);
    end
  endtask

  task automatic run_directed_cases();
    send_simple(OP_FRAME);
    send_simple(OP_UNDEFINED);
    send_simple(OP_BEGIN);
    load_entry(0, 32'sh8000_0000);
    load_entry(1, -5);
    load_entry(2, 100);
    load_entry(3, 200);
    load_entry(4, 300);
    load_entry(5, 32'sh7FFF_FFFF);
    wait_idle();
    write_reg(CFG_STEP_LENGTH, 3);
    write_reg(CFG_RANGE_FIRST, 4095);
    write_reg(CFG_RANGE_LAST, 4095);
    write_reg(CFG_ENTRY_COUNT, 6);
    send_simple(OP_BEGIN);
    wait_idle();
    write_reg(CFG_RANGE_FIRST, 3);
    write_reg(CFG_RANGE_LAST, 2);
    send_simple(OP_BEGIN);
    wait_idle();
    write_reg(CFG_RANGE_FIRST, 2);
    write_reg(CFG_RANGE_LAST, 4095);
    send_simple(OP_BEGIN);
    send_frame(200, 1, 1, 1, 1);
    send_frame(200, 0, 1, 0, 1);
    send_frame(10, 1, 1, 0, 1);
    // Halfway between two entries: the later one wins and takes the first store.
    send_frame(250, 1, 1, 0, 1);
    send_frame(-7, 1, 0, 0, 1);
    repeat (3) send_frame(100, 1, 0, 0, 1);
    repeat (3) send_frame(300, 1, 0, 0, 1);
    repeat (3) send_frame(32'sh7FFF_FFFF, 1, 0, 0, 0);
    wait_idle();
    write_reg(CFG_RANGE_LAST, 4);
    send_simple(OP_BEGIN);
    send_frame(32'sh7FFF_FFFF, 1, 1, 0, 1);
    send_frame(300, 1, 1, 0, 1);
  endtask

  task automatic run_backpressure();
    wait_idle();
    write_reg(CFG_RANGE_LAST, 4095);
    send_simple(OP_BEGIN);
    tx_gaps_on = 1'b0;
    hold_off_cycles = 300;
    repeat (12) send_frame($urandom_range(0, 400), 1, $urandom, 0, 1);
    tx_gaps_on = 1'b1;
    wait_idle();
    drive_run_frames(20);
  endtask

  task automatic run_full_table();
    wait_idle();
    fill_time_table(DEPTH, 1'b1);
    wait_idle();
    write_reg(CFG_ENTRY_COUNT, DEPTH);
    write_reg(CFG_RANGE_FIRST, 4095);
    write_reg(CFG_RANGE_LAST, 4095);
    send_simple(OP_BEGIN);
    drive_run_frames(10);
    wait_idle();
    write_reg(CFG_STEP_LENGTH, 15);
    write_reg(CFG_RANGE_FIRST, 4000);
    send_simple(OP_BEGIN);
    drive_run_frames(40);
    wait_idle();
    write_reg(CFG_STEP_LENGTH, 3);
    write_reg(CFG_RANGE_FIRST, 0);
    send_simple(OP_BEGIN);
    drive_run_frames(30);
  endtask

  task automatic run_random_runs();
    int start, n, p, first, last;
    start = items_sent;
    while (items_sent - start < 1050) begin
      tx_gaps_on = $urandom_range(0, 3) != 0;
      rx_stalls_on = $urandom_range(0, 3) != 0;
      p = $urandom_range(0, 99);
      n = (p < 85) ? $urandom_range(1, 24) : $urandom_range(25, 200);
      fill_time_table(n, $urandom_range(0, 9) != 0);
      wait_idle();
      p = $urandom_range(0, 99);
      write_reg(CFG_STEP_LENGTH, (p < 15) ? 3 : (p < 30) ? 15 : $urandom_range(3, 15));
      write_reg(CFG_ENTRY_COUNT, n);
      first = ($urandom_range(0, 99) < 85) ? $urandom_range(0, n - 1) : $urandom_range(0, 4095);
      p = $urandom_range(0, 99);
      if (p < 10) last = 0;
      else if (p < 40) last = 4095;
      else if (p < 90) last = $urandom_range(first, (first + n > 4095) ? 4095 : first + n);
      else last = $urandom_range(0, 4095);
      write_reg(CFG_RANGE_FIRST, first);
      write_reg(CFG_RANGE_LAST, last);
      send_simple(OP_BEGIN);
      drive_run_frames($urandom_range(20, 60));
    end
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus a long hold-off when a test asks for one.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        hold_off_cycles--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (rx_stalls_on && $urandom_range(0, 99) < 20) begin
        out_ready <= 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result, status", out_status, -1);
      end else begin
        oldest_outcome = pending_outcomes.pop_front();
        if (out_status !== oldest_outcome.status)
          report_mismatch("status", out_status, oldest_outcome.status);
        if (out_index_found !== oldest_outcome.found)
          report_mismatch("index_found", out_index_found, oldest_outcome.found);
        if (out_frame_index !== oldest_outcome.index)
          report_mismatch("frame_index", out_frame_index, oldest_outcome.index);
        if (out_store_frame !== oldest_outcome.store)
          report_mismatch("store_frame", out_store_frame, oldest_outcome.store);
      end
      results_seen++;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_opcode = '0;
    in_entry_index = '0;
    in_entry_time_ms = '0;
    in_frame_time_ms = '0;
    in_has_timestamp = 1'b0;
    in_key_frame = 1'b0;
    in_decode_error = 1'b0;
    in_picture_sound = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed_cases();
    run_backpressure();
    run_full_table();
    run_random_runs();
    park_input();
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[nearest_timestamp_sparse_cache_select_unit] OK");
    end else begin
      $display("[nearest_timestamp_sparse_cache_select_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("[nearest_timestamp_sparse_cache_select_unit] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ntsel_pkg.sv
rtl/ntsel_ram.sv
rtl/nearest_timestamp_sparse_cache_select_unit.sv
sim/nearest_timestamp_sparse_cache_select_unit_tb.sv
